/* sv/mfde_pkg.sv */
// Shared constants and types of the monochrome framebuffer draw engine.
package mfde_pkg;

   localparam int SCR_W = 96;
   localparam int SCR_H = 72;
   localparam int PAGES = (SCR_H + 7) / 8;
   localparam int STORE = SCR_W * PAGES;
   localparam int AW    = $clog2(STORE);
   localparam int CW    = 11;
   localparam int FW    = 18;

   localparam logic [2:0] ACT_CLEAR  = 3'd0;
   localparam logic [2:0] ACT_PIXEL  = 3'd1;
   localparam logic [2:0] ACT_LINE   = 3'd2;
   localparam logic [2:0] ACT_RECT   = 3'd3;
   localparam logic [2:0] ACT_CIRCLE = 3'd4;
   localparam logic [2:0] ACT_FILLED = 3'd5;
   localparam logic [2:0] ACT_READ   = 3'd6;

   typedef logic [AW-1:0]        addr_type;
   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [FW-1:0] acc_type;

endpackage

/* sv/mfde_if.sv */
// Command and read-response channel interfaces.
interface mfde_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] start_x;
   logic [7:0] start_y;
   logic [7:0] end_x;
   logic [7:0] end_y;
   logic [7:0] radius;
   logic       color;
   logic [9:0] read_address;
   modport source (output valid, action, start_x, start_y, end_x, end_y, radius, color,
                   read_address, input ready);
   modport sink (input valid, action, start_x, start_y, end_x, end_y, radius, color,
                 read_address, output ready);
endinterface

interface mfde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

/* sv/mfde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 864
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

/* sv/mono_framebuffer_draw_engine_top.sv */
// Top level of the monochrome framebuffer draw engine.
//
// Drawing engine over a 96x72 page-organized 1-bit framebuffer (864 bytes, each byte holds
// 8 vertical pixels). One command transaction is taken at a time; req_bus.ready is high only
// while the sequencer is idle. Every on-screen pixel is a read-modify-write through the single
// framebuffer RAM port pair: it is fetched, written and then advanced past; an off-screen pixel
// is dropped without a fetch. Lines pass one setup state first, rectangles one per row.
// Clear writes one byte a cycle. After reset a clearing pass zeroes the store before the
// first command is taken. A read returns one rsp transaction; it holds until the output
// register is free, and its result waits there so the next command can start.
module mono_framebuffer_draw_engine_top (
   input logic        clock,
   input logic        reset,
   mfde_req_if.sink   req_bus,
   mfde_rsp_if.source rsp_bus
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_CLR  = 7'b0000010,
      ST_LSET = 7'b0000100,
      ST_PT   = 7'b0001000,
      ST_PW   = 7'b0010000,
      ST_ADV  = 7'b0100000,
      ST_RDW  = 7'b1000000
   } state_type;

   function automatic mfde_pkg::coord_type ext8(input logic [7:0] v);
      ext8 = $signed({{(mfde_pkg::CW-8){1'b0}}, v});
   endfunction

   state_type state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [7:0] x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic color_ff, color_in;
   logic [7:0] fill_ff, fill_in;
   mfde_pkg::addr_type clr_ff, clr_in, wa_ff, wa_in;
   logic [7:0] bit_ff, bit_in;
   logic rd_ok_ff, rd_ok_in;
   logic rsp_v_ff, rsp_v_in;
   logic [7:0] rsp_d_ff, rsp_d_in;
   // line walker
   logic dirx_ff, dirx_in, diry_ff, diry_in, xm_ff, xm_in, endf_ff, endf_in;
   logic [7:0] maj_ff, maj_in, mnr_ff, mnr_in, k_ff, k_in, q_ff, q_in, rem_ff, rem_in;
   logic [7:0] lya_ff, lya_in, lyb_ff, lyb_in, row_ff, row_in;
   // circle walkers
   mfde_pkg::coord_type ca_ff, ca_in, cb_ff, cb_in, fi_ff, fi_in;
   mfde_pkg::acc_type f_ff, f_in, ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic [2:0] idx_ff, idx_in;
   logic fs_ff, fs_in, fr_ff, fr_in;

   mfde_pkg::coord_type px, py;
   logic on_screen;
   mfde_pkg::addr_type addr_pt;
   logic [7:0] bit_pt;
   logic accept;

   logic ram_we, ram_re;
   mfde_pkg::addr_type ram_wa, ram_ra;
   logic [7:0] ram_wd, ram_rd;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_v_ff;
   assign rsp_bus.read_data = rsp_d_ff;

   // Current pixel of the active command, from the walker registers.
   always_comb begin
      mfde_pkg::coord_type a, b, h, w, cx, cy;
      cx = ext8(x1_ff);
      cy = ext8(y1_ff);
      a  = '0;
      b  = '0;
      h  = fs_ff ? ca_ff : cb_ff;
      w  = fs_ff ? cb_ff : ca_ff;
      px = cx;
      py = cy;
      case (cmd_ff)
         mfde_pkg::ACT_LINE, mfde_pkg::ACT_RECT: begin
            a = ext8(xm_ff ? k_ff : q_ff);
            b = ext8(xm_ff ? q_ff : k_ff);
            px = endf_ff ? ext8(x2_ff) : (dirx_ff ? cx - a : cx + a);
            py = endf_ff ? ext8(lyb_ff) : (diry_ff ? ext8(lya_ff) - b : ext8(lya_ff) + b);
         end
         mfde_pkg::ACT_CIRCLE: begin
            a  = idx_ff[2] ? cb_ff : ca_ff;
            b  = idx_ff[2] ? ca_ff : cb_ff;
            px = idx_ff[0] ? cx - a : cx + a;
            py = idx_ff[1] ? cy - b : cy + b;
         end
         mfde_pkg::ACT_FILLED: begin
            px = fi_ff;
            py = fr_ff ? cy - h : cy + h;
         end
         default: begin
            px = cx;
            py = cy;
         end
      endcase
      if (w == '0) begin
         a = '0;
      end
   end

   assign on_screen = (px >= 0) && (py >= 0) && (px < mfde_pkg::SCR_W) &&
                      (py < mfde_pkg::SCR_H);
   assign addr_pt = mfde_pkg::addr_type'(32'(py[7:3]) * mfde_pkg::SCR_W + 32'(px[7:0]));
   assign bit_pt  = 8'(8'd1 << py[2:0]);

   // Sequencer.
   always_comb begin
      logic [7:0] ly1, ly2, mdx, mdy;
      logic [8:0] remn, k1;
      logic [7:0] q1;
      mfde_pkg::coord_type cyn, cxn, wf;
      mfde_pkg::acc_type f1, ddyn, ddxn, e1, xchgn;
      state_in = state_ff;
      cmd_in = cmd_ff;
      x1_in = x1_ff; y1_in = y1_ff; x2_in = x2_ff; y2_in = y2_ff;
      color_in = color_ff; fill_in = fill_ff; clr_in = clr_ff; wa_in = wa_ff;
      bit_in = bit_ff; rd_ok_in = rd_ok_ff; rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff;
      dirx_in = dirx_ff; diry_in = diry_ff; xm_in = xm_ff; endf_in = endf_ff;
      maj_in = maj_ff; mnr_in = mnr_ff; k_in = k_ff; q_in = q_ff; rem_in = rem_ff;
      lya_in = lya_ff; lyb_in = lyb_ff; row_in = row_ff;
      ca_in = ca_ff; cb_in = cb_ff; fi_in = fi_ff;
      f_in = f_ff; ddx_in = ddx_ff; ddy_in = ddy_ff;
      idx_in = idx_ff; fs_in = fs_ff; fr_in = fr_ff;
      ram_we = 1'b0; ram_re = 1'b0;
      ram_wa = clr_ff; ram_wd = fill_ff;
      ram_ra = addr_pt;
      ly1 = (cmd_ff == mfde_pkg::ACT_RECT) ? row_ff : y1_ff;
      ly2 = (cmd_ff == mfde_pkg::ACT_RECT) ? row_ff : y2_ff;
      mdx = (x2_ff < x1_ff) ? x1_ff - x2_ff : x2_ff - x1_ff;
      mdy = (ly2 < ly1) ? ly1 - ly2 : ly2 - ly1;
      remn = 9'(rem_ff) + 9'(mnr_ff);
      k1 = 9'(k_ff) + 9'd1;
      q1 = q_ff;
      cyn = cb_ff; cxn = ca_ff;
      wf = fs_ff ? cb_ff : ca_ff;
      f1 = f_ff; ddyn = ddy_ff; ddxn = ddx_ff; e1 = f_ff; xchgn = ddx_ff;

      // Release the response register once taken.
      if (rsp_v_ff && rsp_bus.ready) begin
         rsp_v_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_bus.action;
               x1_in = req_bus.start_x; y1_in = req_bus.start_y;
               x2_in = req_bus.end_x; y2_in = req_bus.end_y;
               color_in = req_bus.color;
               row_in = req_bus.start_y;
               ca_in = '0;
               cb_in = ext8(req_bus.radius);
               idx_in = '0;
               fs_in = 1'b0; fr_in = 1'b0;
               fi_in = ext8(req_bus.start_x) - ext8(req_bus.radius);
               case (req_bus.action)
                  mfde_pkg::ACT_CLEAR: begin
                     fill_in = req_bus.color ? 8'hFF : 8'h00;
                     clr_in = '0;
                     state_in = ST_CLR;
                  end
                  mfde_pkg::ACT_PIXEL: state_in = ST_PT;
                  mfde_pkg::ACT_LINE: state_in = ST_LSET;
                  mfde_pkg::ACT_RECT: begin
                     state_in = (req_bus.start_y <= req_bus.end_y) ? ST_LSET : ST_IDLE;
                  end
                  mfde_pkg::ACT_CIRCLE: begin
                     f_in = mfde_pkg::acc_type'(1) - mfde_pkg::acc_type'(ext8(req_bus.radius));
                     ddx_in = mfde_pkg::acc_type'(1);
                     ddy_in = -(mfde_pkg::acc_type'(ext8(req_bus.radius)) <<< 1);
                     state_in = ST_PT;
                  end
                  mfde_pkg::ACT_FILLED: begin
                     ca_in = ext8(req_bus.radius);
                     cb_in = '0;
                     f_in = '0;
                     ddy_in = '0;
                     ddx_in = mfde_pkg::acc_type'(1) -
                              (mfde_pkg::acc_type'(ext8(req_bus.radius)) <<< 1);
                     state_in = ST_PT;
                  end
                  mfde_pkg::ACT_READ: begin
                     rd_ok_in = 32'(req_bus.read_address) < mfde_pkg::STORE;
                     ram_ra = mfde_pkg::addr_type'(req_bus.read_address);
                     ram_re = 32'(req_bus.read_address) < mfde_pkg::STORE;
                     state_in = ST_RDW;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == mfde_pkg::addr_type'(mfde_pkg::STORE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_LSET: begin
            lya_in = ly1; lyb_in = ly2;
            dirx_in = x2_ff < x1_ff;
            diry_in = ly2 < ly1;
            xm_in = mdx >= mdy;
            maj_in = (mdx >= mdy) ? mdx : mdy;
            mnr_in = (mdx >= mdy) ? mdy : mdx;
            k_in = '0; q_in = '0; rem_in = '0;
            endf_in = (((mdx >= mdy) ? mdx : mdy) == 8'd0);
            state_in = ST_PT;
         end
         ST_PT: begin
            // Fetch the byte under the pixel; skip dropped pixels.
            ram_re = on_screen;
            wa_in = addr_pt;
            bit_in = bit_pt;
            state_in = on_screen ? ST_PW : ST_ADV;
         end
         ST_PW: begin
            ram_we = 1'b1;
            ram_wa = wa_ff;
            ram_wd = color_ff ? (ram_rd | bit_ff) : (ram_rd & ~bit_ff);
            state_in = ST_ADV;
         end
         ST_ADV: begin
            state_in = ST_PT;
            case (cmd_ff)
               mfde_pkg::ACT_LINE, mfde_pkg::ACT_RECT: begin
                  if (endf_ff) begin
                     if (cmd_ff == mfde_pkg::ACT_RECT && row_ff != y2_ff) begin
                        row_in = row_ff + 8'd1;
                        state_in = ST_LSET;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end else begin
                     if (remn >= 9'(maj_ff)) begin
                        remn = remn - 9'(maj_ff);
                        q1 = q_ff + 8'd1;
                     end
                     rem_in = remn[7:0];
                     q_in = q1;
                     k_in = k1[7:0];
                     endf_in = (k1 == 9'(maj_ff));
                  end
               end
               mfde_pkg::ACT_CIRCLE: begin
                  if (idx_ff != 3'd7) begin
                     idx_in = idx_ff + 3'd1;
                  end else if (ca_ff < cb_ff) begin
                     if (f_ff >= 0) begin
                        cyn = cb_ff - mfde_pkg::coord_type'(1);
                        ddyn = ddy_ff + mfde_pkg::acc_type'(2);
                        f1 = f_ff + ddyn;
                     end
                     ddxn = ddx_ff + mfde_pkg::acc_type'(2);
                     f_in = f1 + ddxn;
                     ddx_in = ddxn;
                     ddy_in = ddyn;
                     cb_in = cyn;
                     ca_in = ca_ff + mfde_pkg::coord_type'(1);
                     idx_in = '0;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               mfde_pkg::ACT_FILLED: begin
                  if (!fr_ff) begin
                     fr_in = 1'b1;
                  end else begin
                     fr_in = 1'b0;
                     if (fi_ff != ext8(x1_ff) + wf) begin
                        fi_in = fi_ff + mfde_pkg::coord_type'(1);
                     end else if (!fs_ff) begin
                        fs_in = 1'b1;
                        fi_in = ext8(x1_ff) - cb_ff;
                     end else begin
                        cyn = cb_ff + mfde_pkg::coord_type'(1);
                        e1 = f_ff + ddy_ff;
                        ddy_in = ddy_ff + mfde_pkg::acc_type'(2);
                        if ((e1 <<< 1) + ddx_ff > 0) begin
                           cxn = ca_ff - mfde_pkg::coord_type'(1);
                           e1 = e1 + ddx_ff;
                           xchgn = ddx_ff + mfde_pkg::acc_type'(2);
                        end
                        f_in = e1;
                        ddx_in = xchgn;
                        ca_in = cxn;
                        cb_in = cyn;
                        fs_in = 1'b0;
                        fi_in = ext8(x1_ff) - cxn;
                        state_in = (cxn >= cyn) ? ST_PT : ST_IDLE;
                     end
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_RDW: begin
            // Hold until the response register is free.
            if (!rsp_v_ff || rsp_bus.ready) begin
               rsp_v_in = 1'b1;
               rsp_d_in = rd_ok_ff ? ram_rd : 8'h00;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         clr_ff   <= '0;
         fill_ff  <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         fill_ff  <= fill_in;
         rsp_v_ff <= rsp_v_in;
      end
      cmd_ff <= cmd_in;
      x1_ff <= x1_in; y1_ff <= y1_in; x2_ff <= x2_in; y2_ff <= y2_in;
      color_ff <= color_in; wa_ff <= wa_in; bit_ff <= bit_in;
      rd_ok_ff <= rd_ok_in; rsp_d_ff <= rsp_d_in;
      dirx_ff <= dirx_in; diry_ff <= diry_in; xm_ff <= xm_in; endf_ff <= endf_in;
      maj_ff <= maj_in; mnr_ff <= mnr_in; k_ff <= k_in; q_ff <= q_in; rem_ff <= rem_in;
      lya_ff <= lya_in; lyb_ff <= lyb_in; row_ff <= row_in;
      ca_ff <= ca_in; cb_ff <= cb_in; fi_ff <= fi_in;
      f_ff <= f_in; ddx_ff <= ddx_in; ddy_ff <= ddy_in;
      idx_ff <= idx_in; fs_ff <= fs_in; fr_ff <= fr_in;
   end

   mfde_ram #(
      .WIDTH(8),
      .DEPTH(mfde_pkg::STORE)
   ) u_frame (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_wa),
      .wdata(ram_wd),
      .re(ram_re),
      .raddr(ram_ra),
      .rdata(ram_rd)
   );

   // A response only appears after the read wait state.
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(state_ff == ST_RDW))
      else $error("response raised outside a read");

   // The store is never written while idle.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("framebuffer write while idle");

   // A pixel write always follows its fetch.
   a_pw_after_pt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PW) |-> $past(state_ff == ST_PT))
      else $error("pixel write without fetch");

endmodule
